>>> src/mdx_pkg.sv
// ----------------------------------------------------------------------------
// mdx_pkg
// Types, codes and defaults shared by the multitap delay crossfade block.
// ----------------------------------------------------------------------------
package mdx_pkg;

    localparam int unsigned DEF_LINE_DEPTH = 65536;
    localparam int unsigned DEF_TAP_COUNT  = 10;
    localparam int unsigned CFG_W          = 17;
    localparam logic [CFG_W-1:0] LINE_LEN_RESET = 17'h10000;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;

    localparam logic KIND_TAP = 1'b0;
    localparam logic KIND_ACK = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] sample_in;
        logic [3:0]         tap_select;
        logic [15:0]        delay_request;
        logic [15:0]        fade_request;
    } t_in_word;

    typedef struct packed {
        logic               kind;
        logic [3:0]         tap_id;
        logic signed [15:0] sample_out;
        logic [15:0]        delay_now;
        logic               last;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_AUDIO,
        CMD_SET,
        CMD_OFF
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic [3:0]         tap;
        logic signed [15:0] sample;
        logic [15:0]        delay;
        logic [15:0]        fade;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_SCAN,
        ST_RD0,
        ST_RD1,
        ST_DIV,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_EMIT
    } t_state;

endpackage

>>> src/mdx_front.sv
// ----------------------------------------------------------------------------
// mdx_front
// Accepts input words, drops ignored ones, clamps delays, forms commands.
// ----------------------------------------------------------------------------
module mdx_front
    import mdx_pkg::*;
#(
    parameter int unsigned TAP_COUNT = DEF_TAP_COUNT,
    parameter int unsigned LW        = 17
) (
    input  logic          i_in_valid,
    input  t_in_word      i_in,
    output logic          o_in_stall,
    input  logic          i_clearing,
    input  logic          i_q_full,
    input  logic [LW-1:0] i_len,
    output logic          o_push,
    output t_cmd          o_cmd
);

    localparam int unsigned XW = (LW > 16) ? LW : 16;

    logic          keep;
    logic [XW-1:0] lim;
    logic          tap_ok;

    assign o_in_stall = i_clearing | i_q_full;
    assign tap_ok     = ({1'b0, i_in.tap_select} < 5'(TAP_COUNT));
    assign lim        = XW'(i_len) - XW'(1);

    always_comb begin
        keep = 1'b0;
        o_cmd.op = CMD_AUDIO;
        unique case (i_in.opcode)
            OP_SAMPLE: begin
                keep = 1'b1;
            end
            OP_SET: begin
                keep = tap_ok;
                o_cmd.op = CMD_SET;
            end
            OP_DISABLE: begin
                keep = tap_ok;
                o_cmd.op = CMD_OFF;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_cmd.tap    = i_in.tap_select;
        o_cmd.sample = i_in.sample_in;
        o_cmd.delay  = (XW'(i_in.delay_request) > lim) ? lim[15:0] : i_in.delay_request;
        o_cmd.fade   = i_in.fade_request;
    end

    assign o_push = i_in_valid & ~o_in_stall & keep;

endmodule

>>> src/mdx_queue.sv
// ----------------------------------------------------------------------------
// mdx_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module mdx_queue
    import mdx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_slot[r_wr] <= i_cmd;
    end

endmodule

>>> src/mdx_div.sv
// ----------------------------------------------------------------------------
// mdx_div
// Restoring divider, one quotient bit per cycle: q = (num << 16) / den,
// for num < den.
// ----------------------------------------------------------------------------
module mdx_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [15:0] o_q
);

    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [15:0] r_q;
    logic [4:0]  r_cnt;
    logic [16:0] shifted;
    logic        ge;

    assign o_busy  = (r_cnt != 5'd0);
    assign o_q     = r_q;
    assign shifted = {r_rem, 1'b0};
    assign ge      = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (o_busy) begin
            r_rem <= ge ? 16'(shifted - {1'b0, r_den}) : shifted[15:0];
            r_q   <= {r_q[14:0], ge};
        end
    end

endmodule

>>> src/mdx_back.sv
// ----------------------------------------------------------------------------
// mdx_back
// Command sequencer: delay line memory, tap state, crossfade datapath and
// output register.
// ----------------------------------------------------------------------------
module mdx_back
    import mdx_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH,
    parameter int unsigned TAP_COUNT  = DEF_TAP_COUNT,
    parameter int unsigned LW         = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [LW-1:0] i_len,
    input  logic          i_q_valid,
    input  t_cmd          i_q_cmd,
    output logic          o_q_pop,
    output logic          o_clearing,
    output logic          o_out_valid,
    output t_out_word     o_out,
    input  logic          i_out_stall
);

    localparam int unsigned AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned TW  = $clog2(TAP_COUNT + 1);
    localparam int unsigned TIW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int unsigned EW  = ((LW > 16) ? LW : 16) + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(LINE_DEPTH - 1);

    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
                                                input logic [15:0] d,
                                                input logic [LW-1:0] n);
        logic [EW-1:0] n1;
        logic [EW-1:0] dc;
        logic [EW-1:0] idx;
        n1 = EW'(n) - EW'(1);
        dc = (EW'(d) > n1) ? n1 : EW'(d);
        if (EW'(wp) >= dc) idx = EW'(wp) - dc;
        else               idx = EW'(wp) + EW'(n) - dc;
        return idx[AW-1:0];
    endfunction

    function automatic logic signed [17:0] trunc16(input logic signed [33:0] p);
        logic signed [33:0] b;
        b = p + (p[33] ? 34'sd65535 : 34'sd0);
        return b[33:16];
    endfunction

    logic signed [15:0] r_mem [LINE_DEPTH];
    logic signed [15:0] r_rd;

    t_state             r_state,  n_state;
    logic [AW-1:0]      r_clr,    n_clr;
    logic [AW-1:0]      r_wp,     n_wp;
    logic [AW-1:0]      r_wpe,    n_wpe;
    t_cmd               r_cmd,    n_cmd;
    logic [TW-1:0]      r_tap,    n_tap;
    logic [TAP_COUNT-1:0] r_active, n_active;
    logic [15:0]        r_delay  [TAP_COUNT];
    logic [15:0]        n_delay  [TAP_COUNT];
    logic [15:0]        r_target [TAP_COUNT];
    logic [15:0]        n_target [TAP_COUNT];
    logic [15:0]        r_remain [TAP_COUNT];
    logic [15:0]        n_remain [TAP_COUNT];
    logic [15:0]        r_total  [TAP_COUNT];
    logic [15:0]        n_total  [TAP_COUNT];
    logic               r_fade,   n_fade;
    logic               r_full,   n_full;
    logic               r_last,   n_last;
    logic signed [15:0] r_s0,     n_s0;
    logic signed [15:0] r_s1,     n_s1;
    logic [16:0]        r_w,      n_w;
    logic signed [33:0] r_p,      n_p;
    logic signed [17:0] r_acc,    n_acc;
    t_out_word          r_res,    n_res;
    logic               r_ov,     n_ov;
    t_out_word          r_o,      n_o;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [15:0] mem_wd;
    logic [AW-1:0]      mem_ra;
    logic               div_start;
    logic               div_busy;
    logic [15:0]        div_q;
    logic [TIW-1:0]     idx;
    logic [TAP_COUNT:0] above;
    logic [AW-1:0]      wpe;
    logic [AW:0]        wp_inc;
    logic signed [17:0] t1;
    logic signed [18:0] sum;
    logic               out_free;

    mdx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_remain[idx]),
        .i_den   (r_total[idx]),
        .o_busy  (div_busy),
        .o_q     (div_q)
    );

    assign idx         = r_tap[TIW-1:0];
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_ov;
    assign o_out       = r_o;
    assign out_free    = ~r_ov | ~i_out_stall;
    assign wpe         = ({1'b0, r_wp} >= (AW+1)'(i_len)) ? '0 : r_wp;
    assign wp_inc      = {1'b0, r_wpe} + (AW+1)'(1);
    assign above       = {1'b0, r_active} >> (r_tap + TW'(1));
    assign t1          = trunc16(r_p);
    assign sum         = {r_acc[17], r_acc} + {t1[17], t1};

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_wp     <= '0;
            r_active <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < TAP_COUNT; i++) begin
                r_delay[i]  <= '0;
                r_target[i] <= '0;
                r_remain[i] <= '0;
                r_total[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_wp     <= n_wp;
            r_active <= n_active;
            r_ov     <= n_ov;
            r_delay  <= n_delay;
            r_target <= n_target;
            r_remain <= n_remain;
            r_total  <= n_total;
        end
        r_wpe  <= n_wpe;
        r_cmd  <= n_cmd;
        r_tap  <= n_tap;
        r_fade <= n_fade;
        r_full <= n_full;
        r_last <= n_last;
        r_s0   <= n_s0;
        r_s1   <= n_s1;
        r_w    <= n_w;
        r_p    <= n_p;
        r_acc  <= n_acc;
        r_res  <= n_res;
        r_o    <= n_o;
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_wp     = r_wp;
        n_wpe    = r_wpe;
        n_cmd    = r_cmd;
        n_tap    = r_tap;
        n_active = r_active;
        n_delay  = r_delay;
        n_target = r_target;
        n_remain = r_remain;
        n_total  = r_total;
        n_fade   = r_fade;
        n_full   = r_full;
        n_last   = r_last;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_w      = r_w;
        n_p      = r_p;
        n_acc    = r_acc;
        n_res    = r_res;
        n_ov     = r_ov & i_out_stall;
        n_o      = r_o;
        mem_we    = 1'b0;
        mem_wa    = r_clr;
        mem_wd    = '0;
        mem_ra    = back_addr(r_wpe, r_delay[idx], i_len);
        div_start = 1'b0;
        o_q_pop   = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == CLR_LAST) n_state = ST_IDLE;
                else                   n_clr = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_tap   = TW'(i_q_cmd.tap);
                    unique case (i_q_cmd.op)
                        CMD_AUDIO: begin
                            mem_we  = 1'b1;
                            mem_wa  = wpe;
                            mem_wd  = i_q_cmd.sample;
                            n_wpe   = wpe;
                            n_tap   = '0;
                            n_state = ST_SCAN;
                        end
                        CMD_SET: n_state = ST_SET;
                        CMD_OFF: n_active[TIW'(i_q_cmd.tap)] = 1'b0;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SET: begin
                n_total[idx] = r_cmd.fade;
                if (!r_active[idx]) begin
                    n_delay[idx]  = r_cmd.delay;
                    n_target[idx] = r_cmd.delay;
                    n_remain[idx] = '0;
                    n_active[idx] = 1'b1;
                end else begin
                    n_target[idx] = r_cmd.delay;
                    n_remain[idx] = r_cmd.fade;
                    if (r_cmd.fade == '0) n_delay[idx] = r_cmd.delay;
                end
                n_res.kind       = KIND_ACK;
                n_res.tap_id     = 4'(r_tap);
                n_res.sample_out = '0;
                n_res.delay_now  = n_delay[idx];
                n_res.last       = 1'b1;
                n_state          = ST_EMIT;
            end
            ST_SCAN: begin
                if (r_tap == TW'(TAP_COUNT)) begin
                    n_wp    = (wp_inc >= (AW+1)'(i_len)) ? '0 : wp_inc[AW-1:0];
                    n_state = ST_IDLE;
                end else if (!r_active[idx]) begin
                    n_tap = r_tap + TW'(1);
                end else begin
                    n_fade = (r_remain[idx] != '0);
                    n_full = (r_total[idx] == '0) || (r_remain[idx] >= r_total[idx]);
                    n_last = (above == '0);
                    div_start = n_fade & ~n_full;
                    n_state = ST_RD0;
                end
            end
            ST_RD0: begin
                n_s0   = r_rd;
                mem_ra = back_addr(r_wpe, r_target[idx], i_len);
                if (r_fade) begin
                    n_state = ST_RD1;
                end else begin
                    n_res.kind       = KIND_TAP;
                    n_res.tap_id     = 4'(r_tap);
                    n_res.sample_out = r_rd;
                    n_res.delay_now  = '0;
                    n_res.last       = r_last;
                    n_state          = ST_EMIT;
                end
            end
            ST_RD1: begin
                n_s1    = r_rd;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    n_w     = r_full ? 17'h10000 : {1'b0, div_q};
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: begin
                n_p     = r_s0 * $signed({1'b0, r_w});
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_acc   = t1;
                n_p     = r_s1 * $signed({1'b0, 17'(17'h10000 - r_w)});
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_res.kind      = KIND_TAP;
                n_res.tap_id    = 4'(r_tap);
                n_res.delay_now = '0;
                n_res.last      = r_last;
                if (sum > 19'sd32767)       n_res.sample_out = 16'sh7fff;
                else if (sum < -19'sd32768) n_res.sample_out = 16'sh8000;
                else                        n_res.sample_out = sum[15:0];
                n_remain[idx] = r_remain[idx] - 16'd1;
                if (r_remain[idx] == 16'd1) n_delay[idx] = r_target[idx];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_o  = r_res;
                    if (r_res.kind == KIND_ACK) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_tap   = r_tap + TW'(1);
                        n_state = ST_SCAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> src/multitap_delay_crossfade.sv
// ----------------------------------------------------------------------------
// multitap_delay_crossfade
// Circular audio delay line with up to TAP_COUNT taps and linear crossfade.
// ----------------------------------------------------------------------------
// channel | dir | handshake               | word
// in      | in  | i_in_valid / o_in_stall | t_in_word
// out     | out | o_out_valid/ i_out_stall| t_out_word
// cfg     | in  | i_cfg_we                | line_length, 17 bits
//
// After reset the line is zeroed, with input stalled. A set emits an ack
// word; a disable emits none. A sample is written, every tap slot is
// scanned, and a fading tap also reads its target, waits on the divider
// unless the weight is full, and multiplies both reads before the sum.
// One word is processed at a time by the back end; a two-entry queue and
// the output register take up stalls on either side.
// ----------------------------------------------------------------------------
module multitap_delay_crossfade
    import mdx_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH,
    parameter int unsigned TAP_COUNT  = DEF_TAP_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_word         i_in,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_word        o_out,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
    localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;

    logic [CFG_W-1:0] r_line_len;
    logic [LW-1:0]    len;
    logic             clearing;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             push;
    t_cmd             f_cmd;
    t_cmd             q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_line_len <= LINE_LEN_RESET;
        else if (i_cfg_we) r_line_len <= i_cfg_data;
    end

    always_comb begin
        if (CW'(r_line_len) < CW'(2))               len = LW'(2);
        else if (CW'(r_line_len) > CW'(LINE_DEPTH)) len = LW'(LINE_DEPTH);
        else                                        len = LW'(r_line_len);
    end

    mdx_front #(.TAP_COUNT(TAP_COUNT), .LW(LW)) u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .i_len      (len),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    mdx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    mdx_back #(.LINE_DEPTH(LINE_DEPTH), .TAP_COUNT(TAP_COUNT), .LW(LW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (len),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_ACK) |-> (o_out.last && o_out.sample_out == '0))
        else $error("ack word malformed");

    a_tap_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_TAP) |-> (o_out.delay_now == '0))
        else $error("tap word carries delay");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out.tap_id} < 5'(TAP_COUNT)))
        else $error("tap id out of range");

    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (o_in_stall && !o_out_valid))
        else $error("activity during line clear");

endmodule
